// ----- rtl/core/cs_pkg.sv -----
// shared constants for the cosine similarity core
// no dependencies; used by cs_solver and cosine_similarity_core
package cs_pkg;

	// default element width and vector length limit
	localparam int ELEM_WIDTH_DEF = 16;
	localparam int MAX_LEN_DEF    = 1024;

	// result format: signed q1.14
	localparam int SIM_WIDTH = 16;
	localparam int FRAC_BITS = 14;
	localparam int ONE_Q14   = 1 << FRAC_BITS;

	// quotient of dot^2 * 2^28 over normx*normy, saturated, and its root
	localparam int QUOT_BITS = 2 * FRAC_BITS + 1;
	localparam int ROOT_BITS = FRAC_BITS + 1;

endpackage

// ----- rtl/core/cs_solver.sv -----
// final similarity step: norm product, squared dot, long division, integer root
// depends on cs_pkg; instantiated by cosine_similarity_core
module cs_solver
	import cs_pkg::*;
#(
	parameter int NW = 42
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [NW:0]    dot_in,
	input  logic [NW-1:0]         nx_in,
	input  logic [NW-1:0]         ny_in,
	input  logic                  ovf_in,
	output logic                  idle,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [SIM_WIDTH-1:0]  res_sim,
	output logic                  res_zn,
	output logic                  res_ovf
);

	localparam int PW   = 2 * NW;
	localparam int CMAX = (NW > QUOT_BITS) ? NW : QUOT_BITS;
	localparam int CNTW = $clog2(CMAX + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_D,
		ST_DIV,
		ST_SQRT,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [CNTW-1:0]       cnt_q;
	logic [PW-1:0]         acc_q;
	logic [PW-1:0]         mcand_q;
	logic [NW-1:0]         mplier_q;
	logic [NW-1:0]         dmag_q;
	logic [PW-1:0]         p_q;
	logic [PW:0]           rem_q;
	logic [QUOT_BITS-1:0]  low_q;
	logic [QUOT_BITS-1:0]  quo_q;
	logic [ROOT_BITS-1:0]  root_q;
	logic                  neg_q;
	logic                  zn_q;
	logic                  ovf_q;
	logic                  out_valid_q;
	logic [SIM_WIDTH-1:0]  out_sim_q;
	logic                  out_zn_q;
	logic                  out_ovf_q;

	// shared shift-add datapath
	logic [PW-1:0]         add_sum;
	logic [PW:0]           div_shift;
	logic [PW:0]           div_diff;
	logic                  div_ge;
	logic [PW:0]           rem_init;
	logic [ROOT_BITS-1:0]  trial;
	logic [2*ROOT_BITS-1:0] trial_sq;
	logic [ROOT_BITS-1:0]  mag;
	logic [SIM_WIDTH-1:0]  sim_val;
	logic [NW:0]           dot_neg;

	assign add_sum   = acc_q + (mplier_q[0] ? mcand_q : '0);
	assign div_shift = {rem_q[PW-1:0], low_q[QUOT_BITS-1]};
	assign div_diff  = div_shift - {1'b0, p_q};
	assign div_ge    = div_shift >= {1'b0, p_q};
	assign rem_init  = {2'b00, add_sum[PW-1:1]};
	assign trial     = root_q | (ROOT_BITS'(1) << (cnt_q - 1'b1));
	assign trial_sq  = trial * trial;
	assign dot_neg   = -dot_in;

	// clamp to one and apply the sign
	always_comb begin
		mag = (root_q > ROOT_BITS'(ONE_Q14)) ? ROOT_BITS'(ONE_Q14) : root_q;
		sim_val = SIM_WIDTH'(mag);
		if (neg_q) begin
			sim_val = -sim_val;
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = out_valid_q;
	assign res_sim   = out_sim_q;
	assign res_zn    = out_zn_q;
	assign res_ovf   = out_ovf_q;

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						neg_q    <= dot_in[NW];
						dmag_q   <= dot_in[NW] ? dot_neg[NW-1:0] : dot_in[NW-1:0];
						ovf_q    <= ovf_in;
						zn_q     <= (nx_in == '0) || (ny_in == '0);
						acc_q    <= '0;
						mcand_q  <= PW'(nx_in);
						mplier_q <= ny_in;
						cnt_q    <= CNTW'(NW);
						root_q   <= '0;
						quo_q    <= '0;
						if ((nx_in == '0) || (ny_in == '0)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL_P;
						end
					end
				end
				// normx * normy, one multiplier bit a cycle
				ST_MUL_P: begin
					acc_q    <= add_sum;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) begin
						p_q      <= add_sum;
						acc_q    <= '0;
						mcand_q  <= PW'(dmag_q);
						mplier_q <= dmag_q;
						cnt_q    <= CNTW'(NW);
						state_q  <= ST_MUL_D;
					end
				end
				// dot magnitude squared
				ST_MUL_D: begin
					acc_q    <= add_sum;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) begin
						if (rem_init >= {1'b0, p_q}) begin
							// quotient beyond range: similarity saturates at one
							root_q  <= ROOT_BITS'(ONE_Q14);
							state_q <= ST_DONE;
						end else begin
							rem_q   <= rem_init;
							low_q   <= {add_sum[0], {(QUOT_BITS-1){1'b0}}};
							cnt_q   <= CNTW'(QUOT_BITS);
							state_q <= ST_DIV;
						end
					end
				end
				// restoring division, one quotient bit a cycle
				ST_DIV: begin
					rem_q <= div_ge ? div_diff : div_shift;
					quo_q <= {quo_q[QUOT_BITS-2:0], div_ge};
					low_q <= low_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) begin
						cnt_q   <= CNTW'(ROOT_BITS);
						state_q <= ST_SQRT;
					end
				end
				// integer root, one result bit a cycle
				ST_SQRT: begin
					if (trial_sq <= (2*ROOT_BITS)'(quo_q)) begin
						root_q <= trial;
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNTW'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || res_ready) begin
						out_valid_q <= 1'b1;
						out_sim_q   <= zn_q ? '0 : sim_val;
						out_zn_q    <= zn_q;
						out_ovf_q   <= ovf_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/cosine_similarity_core.sv -----
// top level of the cosine similarity core: stream ports and accumulators
// depends on cs_pkg and cs_solver
//
// Each element pair request is added into the dot product and both squared
// norms by three parallel multipliers. The request with tlast set starts
// the solver and the input stalls until it finishes, through the bit-serial
// multiplier run twice, the 29-step division, the 15-step root and the
// loading of the result. A zero norm skips the arithmetic and goes straight
// to loading the result. A finished result waits in the output register
// while the next vector streams in; the input stalls longer only while the
// next result finds that register still unread. Pairs beyond MAX_LEN are
// dropped and flagged on the result.
module cosine_similarity_core
	import cs_pkg::*;
#(
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
	parameter int MAX_LEN    = MAX_LEN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// x_elem, y_elem
	input  logic [((2*ELEM_WIDTH+7)/8)*8-1:0]  s_tdata,
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// similarity
	output logic [SIM_WIDTH-1:0]               m_tdata,
	// zero_norm, length_overflow
	output logic [1:0]                         m_tuser
);

	localparam int EW = ELEM_WIDTH;
	localparam int NW = 2 * EW + $clog2(MAX_LEN);
	localparam int DW = NW + 1;
	localparam int CW = $clog2(MAX_LEN + 1);

	logic signed [DW-1:0]  dot_q;
	logic [NW-1:0]         nx_q;
	logic [NW-1:0]         ny_q;
	logic [CW-1:0]         cnt_q;
	logic                  ovf_q;

	logic signed [EW-1:0]   x_elem;
	logic signed [EW-1:0]   y_elem;
	logic signed [2*EW-1:0] xy;
	logic signed [2*EW-1:0] xx_s;
	logic signed [2*EW-1:0] yy_s;
	logic [2*EW-1:0]        xx;
	logic [2*EW-1:0]        yy;
	logic                   take;
	logic                   accept;
	logic signed [DW-1:0]   dot_n;
	logic [NW-1:0]          nx_n;
	logic [NW-1:0]          ny_n;
	logic                   ovf_n;
	logic                   solver_idle;

	assign x_elem = s_tdata[EW-1:0];
	assign y_elem = s_tdata[2*EW-1:EW];

	// products of this pair
	assign xy   = x_elem * y_elem;
	assign xx_s = x_elem * x_elem;
	assign yy_s = y_elem * y_elem;
	assign xx   = xx_s;
	assign yy   = yy_s;

	assign take   = cnt_q < CW'(MAX_LEN);
	assign accept = s_tvalid && s_tready;

	// sums including this pair
	assign dot_n = take ? dot_q + DW'(xy) : dot_q;
	assign nx_n  = take ? nx_q + NW'(xx) : nx_q;
	assign ny_n  = take ? ny_q + NW'(yy) : ny_q;
	assign ovf_n = ovf_q | ~take;

	assign s_tready = solver_idle;

	// accumulators, cleared after the last pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			nx_q  <= '0;
			ny_q  <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				dot_q <= '0;
				nx_q  <= '0;
				ny_q  <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				dot_q <= dot_n;
				nx_q  <= nx_n;
				ny_q  <= ny_n;
				cnt_q <= take ? cnt_q + 1'b1 : cnt_q;
				ovf_q <= ovf_n;
			end
		end
	end

	cs_solver #(
		.NW (NW)
	) u_solver (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && s_tlast),
		.dot_in    (dot_n),
		.nx_in     (nx_n),
		.ny_in     (ny_n),
		.ovf_in    (ovf_n),
		.idle      (solver_idle),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_sim   (m_tdata),
		.res_zn    (m_tuser[0]),
		.res_ovf   (m_tuser[1])
	);

endmodule

// ----- dv/tb.sv -----
// testbench for cosine_similarity_core: directed table then random vectors
// depends on cs_pkg and the core rtl; self-checking against its own predictor
`timescale 1ns / 1ps

module tb;
	import cs_pkg::*;

	localparam int EW      = ELEM_WIDTH_DEF;
	localparam int VLEN    = MAX_LEN_DEF;
	localparam int N_RAND  = 650;
	localparam int WD_MAX  = 3000;
	localparam int HOLD_AT = 30;
	localparam int HOLD_LEN = 600;

	// one pair request, with an optional typed-in expected result
	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic        last;
		logic        typed;
		logic [15:0] sim;
		logic        zn;
		logic        ov;
	} pair_t;

	typedef struct packed {
		logic [15:0] sim;
		logic        zn;
		logic        ov;
	} cos_res_t;

	// directed rows: extremes, zero norms, exact +-1, orthogonal vectors
	localparam int N_DIR = 17;
	localparam pair_t DIR_TBL [N_DIR] = '{
		{16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0},
		{16'h1000, 16'h1000, 1'b1, 1'b1, 16'h4000, 1'b0, 1'b0},
		{16'h1000, 16'hF000, 1'b1, 1'b1, 16'hC000, 1'b0, 1'b0},
		{16'h8000, 16'h8000, 1'b1, 1'b1, 16'h4000, 1'b0, 1'b0},
		{16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'hC000, 1'b0, 1'b0},
		{16'h0000, 16'h0005, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0},
		{16'h1000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		{16'h0000, 16'h1000, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0},
		{16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		{16'h8000, 16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		{16'h7FFF, 16'h8000, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
		{16'h0001, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		{16'hFFFF, 16'h0001, 1'b1, 1'b1, 16'hC000, 1'b0, 1'b0},
		{16'h3000, 16'h1000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		{16'h1000, 16'h3000, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
		{16'h0005, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
		{16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	pair_t    pairs[$];
	cos_res_t cos_exp_q[$];
	int       n_taken = 0;
	int       n_res = 0;
	int       n_err = 0;
	int       idle_cycles = 0;
	bit       drive_done = 0;

	// predictor state
	longint          dot_sum;
	longint unsigned nx_sum, ny_sum;
	int              pair_cnt;
	bit              ovf_seen;

	cosine_similarity_core i_dut (.*);

	always #6 clk = ~clk;

	// largest q in [0, one] with q*q*nx*ny <= dmag^2 * 2^28
	function automatic logic [15:0] cos_mag(longint unsigned dmag, longint unsigned nx,
			longint unsigned ny);
		logic [127:0] p, rhs, lhs, m;
		longint unsigned lo, hi, mid;
		p = 128'(nx) * 128'(ny);
		rhs = (128'(dmag) * 128'(dmag)) << 28;
		lo = 0;
		hi = ONE_Q14;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			m = 128'(mid);
			lhs = p * m * m;
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		return 16'(lo);
	endfunction

	// accumulate one accepted pair; returns 1 with a result on the last pair
	function automatic bit cos_accumulate(logic [15:0] x, logic [15:0] y, logic last,
			output cos_res_t r);
		longint xs, ys;
		longint unsigned dmag;
		logic [15:0] q;
		if (pair_cnt < VLEN) begin
			xs = longint'($signed(x));
			ys = longint'($signed(y));
			dot_sum += xs * ys;
			nx_sum += longint'(xs * xs);
			ny_sum += longint'(ys * ys);
			pair_cnt++;
		end else begin
			ovf_seen = 1;
		end
		r = '0;
		if (!last) return 0;
		if (nx_sum == 0 || ny_sum == 0) begin
			r.zn = 1;
		end else begin
			dmag = (dot_sum < 0) ? longint'(-dot_sum) : longint'(dot_sum);
			q = cos_mag(dmag, nx_sum, ny_sum);
			if (q > ONE_Q14) q = ONE_Q14;
			r.sim = (dot_sum < 0) ? -q : q;
		end
		r.ov = ovf_seen;
		dot_sum = 0;
		nx_sum = 0;
		ny_sum = 0;
		pair_cnt = 0;
		ovf_seen = 0;
		return 1;
	endfunction

	function automatic logic [15:0] rand_elem(int kind);
		case (kind)
			0: return 16'($urandom_range(0, 128)) - 16'd64;
			1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// build a random vector of the given length
	task automatic push_vector(int len, bit last_on_end);
		pair_t p;
		int kind, rel;
		kind = $urandom_range(0, 5);
		rel = $urandom_range(0, 3);
		for (int i = 0; i < len; i++) begin
			p = '0;
			p.x = rand_elem(kind);
			case (rel)
				0: p.y = p.x;
				1: p.y = -p.x;
				default: p.y = rand_elem($urandom_range(0, 5));
			endcase
			p.last = last_on_end && (i == len - 1);
			pairs = {pairs, p};
		end
	endtask

	// stimulus list and reset
	initial begin
		int n;
		dot_sum = 0;
		nx_sum = 0;
		ny_sum = 0;
		pair_cnt = 0;
		ovf_seen = 0;
		for (int i = 0; i < N_DIR; i++) pairs = {pairs, DIR_TBL[i]};
		n = 0;
		while (n < N_RAND) begin
			int len;
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
			push_vector(len, 1);
			n += len;
		end
		// exactly full vector, then one that runs past the limit
		push_vector(VLEN, 1);
		push_vector(VLEN + 3, 1);
		push_vector(3, 1);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// sender
	initial begin
		int gap;
		bit quiet;
		@(posedge arst_n);
		@(posedge clk);
		quiet = 0;
		for (int i = 0; i < pairs.size(); i++) begin
			if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
			gap = quiet ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= {pairs[i].y, pairs[i].x};
			s_tlast <= pairs[i].last;
			do @(posedge clk); while (!s_tready);
		end
		s_tvalid <= 1'b0;
		drive_done = 1;
	end

	// receiver, with one long hold-off so the core backs up
	initial begin
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = (n_res % 50 > 40) ? 0 : $urandom_range(0, 8);
			if (n_res == HOLD_AT) gap = HOLD_LEN;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		cos_res_t r, e;
		bit got;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (s_tvalid && s_tready) begin
				got = cos_accumulate(s_tdata[15:0], s_tdata[31:16], s_tlast, r);
				if (got) begin
					if (pairs[n_taken].typed) begin
						r.sim = pairs[n_taken].sim;
						r.zn = pairs[n_taken].zn;
						r.ov = pairs[n_taken].ov;
					end
					cos_exp_q = {cos_exp_q, r};
				end
				n_taken <= n_taken + 1;
			end
			if (m_tvalid && m_tready) begin
				n_res <= n_res + 1;
				if (cos_exp_q.size() == 0) begin
					$display("%0t: unexpected result sim=%h user=%b", $time, m_tdata, m_tuser);
					n_err++;
				end else begin
					e = cos_exp_q.pop_front();
					if (m_tdata !== e.sim) begin
						$display("%0t: similarity expected %h actual %h", $time, e.sim, m_tdata);
						n_err++;
					end
					if (m_tuser[0] !== e.zn) begin
						$display("%0t: zero_norm expected %b actual %b", $time, e.zn, m_tuser[0]);
						n_err++;
					end
					if (m_tuser[1] !== e.ov) begin
						$display("%0t: length_overflow expected %b actual %b", $time, e.ov,
							m_tuser[1]);
						n_err++;
					end
				end
			end
			if (idle_cycles >= WD_MAX) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// end of run
	initial begin
		@(posedge arst_n);
		while (!drive_done || n_taken < pairs.size() || cos_exp_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (n_err == 0 && cos_exp_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
